// ----- hdl/prg_pkg.sv -----
// Shared types, constants and arithmetic helpers of the perspective ray generator.
package prg_pkg;

    localparam int COORD_W   = 20;
    localparam int FRAC_BITS = 12;
    localparam int RES_W     = 12;
    localparam int CFG_W     = 60;
    localparam int IDX_W     = 3;
    localparam int PITCH_W   = 19;
    localparam int VEC_W     = 42;
    localparam int MAG_W     = VEC_W - 1;
    localparam int NORM_W    = 30;
    localparam int SS_W      = 2 * NORM_W + 2;
    localparam int SQ_W      = 63;
    localparam int LEN_W     = 32;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int NUM_W     = LEN_W + FRAC_BITS + 1;
    localparam int DIR_W     = QUO_W + 1;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int UNIT_LAT  = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;
    localparam int WARM_CYC  = UNIT_LAT + 8;
    localparam int WARM_W    = $clog2(WARM_CYC + 1);

    localparam logic [IDX_W-1:0] REG_CAMERA   = 3'd0;
    localparam logic [IDX_W-1:0] REG_VIEW     = 3'd1;
    localparam logic [IDX_W-1:0] REG_UP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_HRES     = 3'd3;
    localparam logic [IDX_W-1:0] REG_VRES     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PITCH    = 3'd5;
    localparam logic [IDX_W-1:0] REG_TANGENT  = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [VEC_W-1:0]   wide_t;
    typedef logic signed [DIR_W-1:0]   ucomp_t;
    typedef wide_t  wvec_t [3];
    typedef ucomp_t ucvec_t [3];

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cvec_t;

    typedef struct packed {
        cvec_t org;
        cvec_t dir;
    } ray_t;

    // Product scaled down by 2^sh, rounded to nearest with halves away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                       input int unsigned sh);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ----- hdl/prg_unit.sv -----
// Pipelined vector normalizer: scale, sum of squares, square root and per-lane division.
module prg_unit (
    input  logic            clk,
    input  logic            en,
    input  prg_pkg::wvec_t  vec_in,
    output prg_pkg::ucvec_t dir_out
);
    import prg_pkg::*;

    logic [MAG_W-1:0]  u1_mag_reg [3];
    logic [2:0]        u1_neg_reg;
    logic [MAG_W-1:0]  u2_mag_reg [3];
    logic [2:0]        u2_neg_reg;
    logic [MAG_W-1:0]  u2_mx_reg;
    logic [MAG_W-1:0]  u3_mag_reg [3];
    logic [2:0]        u3_neg_reg;
    logic [5:0]        u3_pos_reg;
    logic              u3_zero_reg;
    logic [NORM_W-1:0] u4_nm_reg [3];
    logic [2:0]        u4_neg_reg;
    logic              u4_zero_reg;
    logic [2*NORM_W-1:0] u5_sq_reg [3];
    logic [NORM_W-1:0] u5_nm_reg [3];
    logic [2:0]        u5_neg_reg;
    logic              u5_zero_reg;
    logic [SS_W-1:0]   u6_ss_reg;
    logic [NORM_W-1:0] u6_nm_reg [3];
    logic [2:0]        u6_neg_reg;
    logic              u6_zero_reg;

    logic [SQ_W-1:0]   sq_x_reg [SQ_STEPS];
    logic [SQ_W-1:0]   sq_r_reg [SQ_STEPS];
    logic [NORM_W-1:0] sq_nm_reg [SQ_STEPS][3];
    logic [2:0]        sq_neg_reg [SQ_STEPS];
    logic              sq_zero_reg [SQ_STEPS];
    logic [SQ_W-1:0]   sq_src_x [SQ_STEPS];
    logic [SQ_W-1:0]   sq_src_r [SQ_STEPS];
    logic [SQ_W-1:0]   sq_x_next [SQ_STEPS];
    logic [SQ_W-1:0]   sq_r_next [SQ_STEPS];

    logic [NUM_W-1:0]  d0_n_reg [3];
    logic [LEN_W-1:0]  d0_len_reg;
    logic [2:0]        d0_neg_reg;
    logic              d0_zero_reg;

    logic [NUM_W-1:0]  dv_rem_reg [DIV_STEPS][3];
    logic [QUO_W-1:0]  dv_q_reg [DIV_STEPS][3];
    logic [LEN_W-1:0]  dv_len_reg [DIV_STEPS];
    logic [2:0]        dv_neg_reg [DIV_STEPS];
    logic              dv_zero_reg [DIV_STEPS];
    logic [NUM_W-1:0]  dv_src_rem [DIV_STEPS][3];
    logic [QUO_W-1:0]  dv_src_q [DIV_STEPS][3];
    logic [LEN_W-1:0]  dv_src_len [DIV_STEPS];
    logic [NUM_W-1:0]  dv_rem_next [DIV_STEPS][3];
    logic [QUO_W-1:0]  dv_q_next [DIV_STEPS][3];

    ucomp_t            dir_reg [3];

    function automatic logic [5:0] msb_pos(input logic [MAG_W-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    always_comb
    begin
        sq_src_x[0] = SQ_W'(u6_ss_reg);
        sq_src_r[0] = '0;
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            sq_src_x[k] = sq_x_reg[k-1];
            sq_src_r[k] = sq_r_reg[k-1];
        end
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (sq_src_x[k] >= sq_src_r[k] + (SQ_W'(1) << (2 * (SQ_STEPS - 1 - k))))
            begin
                sq_x_next[k] = sq_src_x[k] - (sq_src_r[k]
                             + (SQ_W'(1) << (2 * (SQ_STEPS - 1 - k))));
                sq_r_next[k] = (sq_src_r[k] >> 1) + (SQ_W'(1) << (2 * (SQ_STEPS - 1 - k)));
            end
            else
            begin
                sq_x_next[k] = sq_src_x[k];
                sq_r_next[k] = sq_src_r[k] >> 1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_src_rem[0][i] = d0_n_reg[i];
            dv_src_q[0][i]   = '0;
        end
        dv_src_len[0] = d0_len_reg;
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_src_rem[j][i] = dv_rem_reg[j-1][i];
                dv_src_q[j][i]   = dv_q_reg[j-1][i];
            end
            dv_src_len[j] = dv_len_reg[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_src_rem[j][i] >= (NUM_W'(dv_src_len[j]) << (DIV_STEPS - 1 - j)))
                begin
                    dv_rem_next[j][i] = dv_src_rem[j][i]
                                      - (NUM_W'(dv_src_len[j]) << (DIV_STEPS - 1 - j));
                    dv_q_next[j][i]   = dv_src_q[j][i] | (QUO_W'(1) << (DIV_STEPS - 1 - j));
                end
                else
                begin
                    dv_rem_next[j][i] = dv_src_rem[j][i];
                    dv_q_next[j][i]   = dv_src_q[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u1_neg_reg[i] <= vec_in[i][VEC_W-1];
                u1_mag_reg[i] <= vec_in[i][VEC_W-1] ? MAG_W'(-vec_in[i]) : MAG_W'(vec_in[i]);
            end

            u2_mag_reg <= u1_mag_reg;
            u2_neg_reg <= u1_neg_reg;
            if (u1_mag_reg[0] >= u1_mag_reg[1] && u1_mag_reg[0] >= u1_mag_reg[2])
            begin
                u2_mx_reg <= u1_mag_reg[0];
            end
            else if (u1_mag_reg[1] >= u1_mag_reg[2])
            begin
                u2_mx_reg <= u1_mag_reg[1];
            end
            else
            begin
                u2_mx_reg <= u1_mag_reg[2];
            end

            u3_mag_reg  <= u2_mag_reg;
            u3_neg_reg  <= u2_neg_reg;
            u3_pos_reg  <= msb_pos(u2_mx_reg);
            u3_zero_reg <= (u2_mx_reg == '0);

            for (int i = 0; i < 3; i++)
            begin
                if (u3_pos_reg >= 6'(NORM_W))
                begin
                    u4_nm_reg[i] <= NORM_W'(u3_mag_reg[i] >> (u3_pos_reg - 6'(NORM_W - 1)));
                end
                else if (u3_pos_reg < 6'(NORM_W - 2))
                begin
                    u4_nm_reg[i] <= NORM_W'(u3_mag_reg[i] << (6'(NORM_W - 2) - u3_pos_reg));
                end
                else
                begin
                    u4_nm_reg[i] <= NORM_W'(u3_mag_reg[i]);
                end
            end
            u4_neg_reg  <= u3_neg_reg;
            u4_zero_reg <= u3_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                u5_sq_reg[i] <= u4_nm_reg[i] * u4_nm_reg[i];
            end
            u5_nm_reg   <= u4_nm_reg;
            u5_neg_reg  <= u4_neg_reg;
            u5_zero_reg <= u4_zero_reg;

            u6_ss_reg   <= SS_W'(u5_sq_reg[0]) + SS_W'(u5_sq_reg[1]) + SS_W'(u5_sq_reg[2]);
            u6_nm_reg   <= u5_nm_reg;
            u6_neg_reg  <= u5_neg_reg;
            u6_zero_reg <= u5_zero_reg;

            sq_nm_reg[0]   <= u6_nm_reg;
            sq_neg_reg[0]  <= u6_neg_reg;
            sq_zero_reg[0] <= u6_zero_reg;
            for (int k = 1; k < SQ_STEPS; k++)
            begin
                sq_nm_reg[k]   <= sq_nm_reg[k-1];
                sq_neg_reg[k]  <= sq_neg_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
            end
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_x_reg[k] <= sq_x_next[k];
                sq_r_reg[k] <= sq_r_next[k];
            end

            for (int i = 0; i < 3; i++)
            begin
                d0_n_reg[i] <= (NUM_W'(sq_nm_reg[SQ_STEPS-1][i]) << FRAC_BITS)
                             + NUM_W'(sq_r_reg[SQ_STEPS-1][LEN_W-1:1]);
            end
            d0_len_reg  <= sq_r_reg[SQ_STEPS-1][LEN_W-1:0];
            d0_neg_reg  <= sq_neg_reg[SQ_STEPS-1];
            d0_zero_reg <= sq_zero_reg[SQ_STEPS-1];

            dv_len_reg[0]  <= d0_len_reg;
            dv_neg_reg[0]  <= d0_neg_reg;
            dv_zero_reg[0] <= d0_zero_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                dv_len_reg[j]  <= dv_len_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
            end
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end

            for (int i = 0; i < 3; i++)
            begin
                if (dv_zero_reg[DIV_STEPS-1])
                begin
                    dir_reg[i] <= '0;
                end
                else if (dv_neg_reg[DIV_STEPS-1][i])
                begin
                    dir_reg[i] <= -$signed({1'b0, dv_q_reg[DIV_STEPS-1][i]});
                end
                else
                begin
                    dir_reg[i] <= $signed({1'b0, dv_q_reg[DIV_STEPS-1][i]});
                end
            end
        end
    end

    assign dir_out = dir_reg;

endmodule

// ----- hdl/perspective_ray_generator.sv -----
// Top level of the perspective ray generator: configuration, ray pipeline and output buffer.
//
// Usage: software writes the camera through the plain write port (cfg_write_enable,
// cfg_index, cfg_data) while no pixel is in flight. Each pixel word enters on the
// in_valid/in_ready channel and one ray word leaves on out_valid/out_ready.
// Throughput is one pixel per cycle when the receiver does not stall, set by the fully
// pipelined square root (32 stages) and the three per-lane dividers (13 stages).
// After reset and after every configuration write the block derives the focal
// length, the side vector and the unit up vector; in_ready stays low while it
// does so. Reset clears the valid flags, restarts the derivation and loads the
// default camera.
// When the receiver stalls, the output register holds its word and a second
// word is parked in a skid register; only then does the pipeline freeze and
// in_ready drop, so no word is lost or repeated.
module perspective_ray_generator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_enable,
    input  logic [prg_pkg::IDX_W-1:0]              cfg_index,
    input  logic [prg_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [prg_pkg::RES_W-1:0]              pixel_col,
    input  logic [prg_pkg::RES_W-1:0]              pixel_row,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [prg_pkg::COORD_W-1:0]     origin_x,
    output logic signed [prg_pkg::COORD_W-1:0]     origin_y,
    output logic signed [prg_pkg::COORD_W-1:0]     origin_z,
    output logic signed [prg_pkg::COORD_W-1:0]     direction_x,
    output logic signed [prg_pkg::COORD_W-1:0]     direction_y,
    output logic signed [prg_pkg::COORD_W-1:0]     direction_z
);
    import prg_pkg::*;

    logic [CFG_W-1:0]   cam_reg;
    logic [CFG_W-1:0]   fwd_reg;
    logic [CFG_W-1:0]   up_reg;
    logic [RES_W:0]     hres_reg;
    logic [RES_W:0]     vres_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [PITCH_W-1:0] tan_reg;

    logic [WARM_W-1:0]  warm_cnt_reg;
    logic               restart_reg;
    logic [4:0]         fcnt_reg;
    logic [NUM_W-1:0]   frem_reg;
    logic [PITCH_W-1:0] fq_reg;

    cvec_t              cam_v;
    cvec_t              fwd_v;
    cvec_t              up_v;
    coord_t             cam_c [3];
    coord_t             fwd_c [3];
    coord_t             up_c [3];
    logic [2*RES_W+8:0] view_w;
    logic [NUM_W-1:0]   fnum;
    logic [PITCH_W:0]   tan2;
    logic [NUM_W-1:0]   fdvs;

    logic signed [2*COORD_W-1:0] cp_reg [6];
    wvec_t                       cross_reg;
    wvec_t                       up_wide;
    ucvec_t                      side;
    ucvec_t                      upn;
    logic signed [2*COORD_W-1:0] bf_reg [3];
    logic signed [DIR_W+PITCH_W:0] bn_reg [3];
    wide_t                       base_reg [3];

    logic                        en;
    logic                        accept;
    logic signed [RES_W+2:0]     dc;
    logic signed [RES_W+2:0]     dr;
    logic                        s1_v_reg;
    logic signed [34:0]          s1_tr_reg;
    logic signed [34:0]          s1_td_reg;
    logic                        s2_v_reg;
    logic signed [48:0]          s2_ps_reg [3];
    logic signed [54:0]          s2_pu_reg [3];
    logic                        s3_v_reg;
    wide_t                       s3_rs_reg [3];
    wide_t                       s3_ru_reg [3];
    logic                        s4_v_reg;
    wvec_t                       s4_dsum_reg;
    coord_t                      org_sat [3];
    logic signed [VEC_W:0]       org_full [3];
    logic                        dl_v_reg [UNIT_LAT];
    cvec_t                       dl_org_reg [UNIT_LAT];
    ucvec_t                      unit_dir;

    ray_t                        word;
    ray_t                        out_reg;
    ray_t                        skid_reg;
    logic                        out_v_reg;
    logic                        skid_v_reg;
    logic                        push;
    logic                        pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg   <= '0;
            fwd_reg   <= CFG_W'(4096);
            up_reg    <= CFG_W'(64'd4294967296);
            hres_reg  <= (RES_W + 1)'(640);
            vres_reg  <= (RES_W + 1)'(480);
            pitch_reg <= PITCH_W'(4096);
            tan_reg   <= PITCH_W'(4096);
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_CAMERA:  cam_reg   <= cfg_data;
                REG_VIEW:    fwd_reg   <= cfg_data;
                REG_UP:      up_reg    <= cfg_data;
                REG_HRES:    hres_reg  <= cfg_data[RES_W:0];
                REG_VRES:    vres_reg  <= cfg_data[RES_W:0];
                REG_PITCH:   pitch_reg <= cfg_data[PITCH_W-1:0];
                REG_TANGENT: tan_reg   <= cfg_data[PITCH_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= WARM_W'(WARM_CYC);
            restart_reg  <= 1'b1;
        end
        else
        begin
            restart_reg <= cfg_write_enable;
            if (cfg_write_enable)
            begin
                warm_cnt_reg <= WARM_W'(WARM_CYC);
            end
            else if (warm_cnt_reg != '0)
            begin
                warm_cnt_reg <= warm_cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        cam_v = cvec_t'(cam_reg);
        fwd_v = cvec_t'(fwd_reg);
        up_v  = cvec_t'(up_reg);
        cam_c[0] = cam_v.x;
        cam_c[1] = cam_v.y;
        cam_c[2] = cam_v.z;
        fwd_c[0] = fwd_v.x;
        fwd_c[1] = fwd_v.y;
        fwd_c[2] = fwd_v.z;
        up_c[0]  = up_v.x;
        up_c[1]  = up_v.y;
        up_c[2]  = up_v.z;
        for (int i = 0; i < 3; i++)
        begin
            up_wide[i] = VEC_W'(up_c[i]);
        end
    end

    // Focal length: restoring divider, one quotient bit per cycle.
    assign view_w = hres_reg * pitch_reg;
    assign fnum   = (NUM_W'(view_w) << FRAC_BITS) + NUM_W'(tan_reg);
    assign tan2   = {tan_reg, 1'b0};
    assign fdvs   = NUM_W'(tan2) << (fcnt_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
        end
        else if (restart_reg)
        begin
            if (tan_reg == '0 || fnum >= (NUM_W'(tan2) << PITCH_W))
            begin
                fcnt_reg <= '0;
            end
            else
            begin
                fcnt_reg <= 5'(PITCH_W);
            end
        end
        else if (fcnt_reg != '0)
        begin
            fcnt_reg <= fcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (restart_reg)
        begin
            frem_reg <= fnum;
            if (tan_reg == '0 || fnum >= (NUM_W'(tan2) << PITCH_W))
            begin
                fq_reg <= '1;
            end
            else
            begin
                fq_reg <= '0;
            end
        end
        else if (fcnt_reg != '0 && frem_reg >= fdvs)
        begin
            frem_reg                 <= frem_reg - fdvs;
            fq_reg[fcnt_reg - 1'b1]  <= 1'b1;
        end
    end

    // Camera-derived vectors, recomputed continuously from the registers.
    always_ff @(posedge clk)
    begin
        cp_reg[0] <= fwd_c[1] * up_c[2];
        cp_reg[1] <= fwd_c[2] * up_c[1];
        cp_reg[2] <= fwd_c[2] * up_c[0];
        cp_reg[3] <= fwd_c[0] * up_c[2];
        cp_reg[4] <= fwd_c[0] * up_c[1];
        cp_reg[5] <= fwd_c[1] * up_c[0];
        for (int i = 0; i < 3; i++)
        begin
            cross_reg[i] <= VEC_W'(round_shift(64'(cp_reg[2*i]), FRAC_BITS)
                                 - round_shift(64'(cp_reg[2*i+1]), FRAC_BITS));
            bf_reg[i]    <= fwd_c[i] * $signed({1'b0, fq_reg});
            bn_reg[i]    <= upn[i] * $signed({1'b0, pitch_reg});
            base_reg[i]  <= VEC_W'(round_shift(64'(bf_reg[i]), FRAC_BITS)
                                 - round_shift(64'(bn_reg[i]), FRAC_BITS + 1));
        end
    end

    prg_unit u_side (
        .clk     (clk),
        .en      (1'b1),
        .vec_in  (cross_reg),
        .dir_out (side)
    );

    prg_unit u_upn (
        .clk     (clk),
        .en      (1'b1),
        .vec_in  (up_wide),
        .dir_out (upn)
    );

    // Pixel pipeline.
    assign en       = !skid_v_reg;
    assign in_ready = en && (warm_cnt_reg == '0);
    assign accept   = in_valid && in_ready;
    assign dc       = $signed({2'b00, pixel_col, 1'b1}) - $signed({2'b00, hres_reg});
    assign dr       = $signed({2'b00, vres_reg}) - $signed({2'b00, pixel_row, 1'b0});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            org_full[i] = (VEC_W + 1)'(cam_c[i]) + (VEC_W + 1)'(s4_dsum_reg[i]);
            if (org_full[i] > (VEC_W + 1)'(2 ** (COORD_W - 1) - 1))
            begin
                org_sat[i] = {1'b0, {(COORD_W - 1){1'b1}}};
            end
            else if (org_full[i] < -(VEC_W + 1)'(2 ** (COORD_W - 1)))
            begin
                org_sat[i] = {1'b1, {(COORD_W - 1){1'b0}}};
            end
            else
            begin
                org_sat[i] = COORD_W'(org_full[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            for (int k = 0; k < UNIT_LAT; k++)
            begin
                dl_v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_v_reg    <= accept;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            dl_v_reg[0] <= s4_v_reg;
            for (int k = 1; k < UNIT_LAT; k++)
            begin
                dl_v_reg[k] <= dl_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tr_reg <= $signed({1'b0, pitch_reg}) * dc;
            s1_td_reg <= $signed({1'b0, pitch_reg}) * dr;
            for (int i = 0; i < 3; i++)
            begin
                s2_ps_reg[i]   <= side[i] * s1_tr_reg;
                s2_pu_reg[i]   <= up_c[i] * s1_td_reg;
                s3_rs_reg[i]   <= VEC_W'(round_shift(64'(s2_ps_reg[i]), FRAC_BITS + 1));
                s3_ru_reg[i]   <= VEC_W'(round_shift(64'(s2_pu_reg[i]), FRAC_BITS + 1));
                s4_dsum_reg[i] <= base_reg[i] + s3_rs_reg[i] + s3_ru_reg[i];
            end
            dl_org_reg[0] <= '{x: org_sat[0], y: org_sat[1], z: org_sat[2]};
            for (int k = 1; k < UNIT_LAT; k++)
            begin
                dl_org_reg[k] <= dl_org_reg[k-1];
            end
        end
    end

    prg_unit u_dir (
        .clk     (clk),
        .en      (en),
        .vec_in  (s4_dsum_reg),
        .dir_out (unit_dir)
    );

    // Output register with one skid word.
    always_comb
    begin
        word.org   = dl_org_reg[UNIT_LAT-1];
        word.dir.x = COORD_W'(unit_dir[0]);
        word.dir.y = COORD_W'(unit_dir[1]);
        word.dir.z = COORD_W'(unit_dir[2]);
    end

    assign push = en && dl_v_reg[UNIT_LAT-1];
    assign pop  = out_v_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!skid_v_reg)
        begin
            if (push)
            begin
                if (!out_v_reg || pop)
                begin
                    out_v_reg <= 1'b1;
                end
                else
                begin
                    skid_v_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
        else if (pop)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            if (push && (!out_v_reg || pop))
            begin
                out_reg <= word;
            end
            else if (push)
            begin
                skid_reg <= word;
            end
        end
        else if (pop)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_v_reg;
    assign origin_x    = out_reg.org.x;
    assign origin_y    = out_reg.org.y;
    assign origin_z    = out_reg.org.z;
    assign direction_x = out_reg.dir.x;
    assign direction_y = out_reg.dir.y;
    assign direction_z = out_reg.dir.z;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("Skid word held without an output word.");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_enable |=> !in_ready)
        else $error("Pixel input open right after a configuration write.");

    a_frozen_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en && dl_v_reg[UNIT_LAT-1] |=> dl_v_reg[UNIT_LAT-1]
            && $stable(dl_org_reg[UNIT_LAT-1]))
        else $error("Pipeline tail changed while frozen.");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the perspective ray generator: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import prg_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 325;

    typedef longint vec3_t [3];
    typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;
    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        logic [RES_W-1:0] col;
        logic [RES_W-1:0] row;
        bit               typed;
        cvec_t            org;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_enable;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [RES_W-1:0]    pixel_col;
    logic [RES_W-1:0]    pixel_row;
    logic                out_valid;
    logic                out_ready;
    coord_t              origin_x, origin_y, origin_z;
    coord_t              direction_x, direction_y, direction_z;

    logic [CFG_W-1:0]    camera_regs [7];
    ray_t                ray_q [$];
    stim_row_t           stim_rows [$];
    int                  send_idle;
    int                  recv_idle;
    int                  mismatches;
    int                  pixels_sent;
    int                  rays_checked;
    int                  writes_done;

    perspective_ray_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_col(pixel_col), .pixel_row(pixel_row),
        .out_valid(out_valid), .out_ready(out_ready),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .direction_x(direction_x), .direction_y(direction_y), .direction_z(direction_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [CFG_W-1:0] reg_mask(logic [IDX_W-1:0] idx);
        case (idx)
            REG_HRES, REG_VRES:     return (60'd1 << 13) - 1;
            REG_PITCH, REG_TANGENT: return (60'd1 << 19) - 1;
            default:                return '1;
        endcase
    endfunction

    function automatic longint scaled_product(longint a, longint b, int sh);
        logic [63:0] ua, ub, r;
        logic        neg;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        if (ua != 0 && ub > (64'd1 << 62) / ua)
            r = (64'd1 << 46) - 1;
        else
        begin
            r = (ua * ub + (64'd1 << (sh - 1))) >> sh;
            if (r > (64'd1 << 46) - 1)
                r = (64'd1 << 46) - 1;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic vec3_t normalize(vec3_t v);
        logic [63:0] m [3];
        logic [63:0] mx, ss, len;
        vec3_t       r;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            r = '{0, 0, 0};
            return r;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 28))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        ss = 0;
        for (int i = 0; i < 3; i++)
            ss += m[i] * m[i];
        len = floor_sqrt(ss);
        for (int i = 0; i < 3; i++)
        begin
            r[i] = longint'(((m[i] << FRAC_BITS) + len / 2) / len);
            if (v[i] < 0)
                r[i] = -r[i];
        end
        return r;
    endfunction

    function automatic vec3_t unpack_vec(logic [CFG_W-1:0] p);
        vec3_t v;
        v[0] = longint'($signed(p[59:40]));
        v[1] = longint'($signed(p[39:20]));
        v[2] = longint'($signed(p[19:0]));
        return v;
    endfunction

    function automatic coord_t saturate(longint v);
        if (v > 524287)
            return 20'sh7FFFF;
        if (v < -524288)
            return 20'sh80000;
        return coord_t'(v);
    endfunction

    function automatic ray_t trace_pixel(logic [RES_W-1:0] col, logic [RES_W-1:0] row);
        vec3_t       cam, fwd, upv, cr, side, upn, org, dir;
        longint      hres, vres, pitch, focal, tr, td;
        logic [63:0] tan2, vw, q;
        coord_t      o [3], d [3];
        ray_t        r;
        cam = unpack_vec(camera_regs[REG_CAMERA]);
        fwd = unpack_vec(camera_regs[REG_VIEW]);
        upv = unpack_vec(camera_regs[REG_UP]);
        hres = longint'(camera_regs[REG_HRES]);
        vres = longint'(camera_regs[REG_VRES]);
        pitch = longint'(camera_regs[REG_PITCH]);
        tan2 = 64'(camera_regs[REG_TANGENT]) * 2;
        if (tan2 == 0)
            focal = 524287;
        else
        begin
            vw = 64'(hres) * 64'(pitch);
            q = ((vw << FRAC_BITS) + tan2 / 2) / tan2;
            focal = (q > 524287) ? 524287 : longint'(q);
        end
        cr[0] = scaled_product(fwd[1], upv[2], 12) - scaled_product(fwd[2], upv[1], 12);
        cr[1] = scaled_product(fwd[2], upv[0], 12) - scaled_product(fwd[0], upv[2], 12);
        cr[2] = scaled_product(fwd[0], upv[1], 12) - scaled_product(fwd[1], upv[0], 12);
        side = normalize(cr);
        upn = normalize(upv);
        tr = pitch * (2 * longint'(col) + 1 - hres);
        td = pitch * (vres - 2 * longint'(row));
        for (int i = 0; i < 3; i++)
        begin
            org[i] = cam[i] + scaled_product(fwd[i], focal, 12)
                   + scaled_product(side[i], tr, 13)
                   + scaled_product(upv[i], td, 13)
                   - scaled_product(upn[i], pitch, 13);
            dir[i] = org[i] - cam[i];
        end
        dir = normalize(dir);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = saturate(org[i]);
            d[i] = saturate(dir[i]);
        end
        r.org = '{o[0], o[1], o[2]};
        r.dir = '{d[0], d[1], d[2]};
        return r;
    endfunction

    function automatic void add_pixel(int col, int row, bit typed = 0,
                                      int ox = 0, int oy = 0, int oz = 0);
        stim_row_t s;
        s.kind = ROW_PIXEL;
        s.idx = '0;
        s.data = '0;
        s.col = RES_W'(col);
        s.row = RES_W'(row);
        s.typed = typed;
        s.org = '{coord_t'(ox), coord_t'(oy), coord_t'(oz)};
        stim_rows.push_back(s);
    endfunction

    function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t s;
        s = '{kind: ROW_WRITE, idx: idx, data: data, col: '0, row: '0, typed: 0, org: '0};
        stim_rows.push_back(s);
    endfunction

    function automatic logic [CFG_W-1:0] pack_vec(int x, int y, int z);
        return {20'(x), 20'(y), 20'(z)};
    endfunction

    function automatic int rand_comp();
        return $urandom_range(8192) - 4096;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(logic [RES_W-1:0] col, logic [RES_W-1:0] row, bit typed,
                              cvec_t org);
        ray_t r;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        r = trace_pixel(col, row);
        if (typed)
            r.org = org;
        ray_q.push_back(r);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        in_valid <= 1'b0;
        @(negedge clk);
        while (ray_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx <= REG_TANGENT)
            camera_regs[idx] = data & reg_mask(idx);
        writes_done++;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin : check_rays
        ray_t   e;
        coord_t exp_f [6];
        coord_t act_f [6];
        string  names [6];
        if (rst_n && out_valid && out_ready)
        begin
            if (ray_q.size() == 0)
            begin
                $error("ray with no pixel pending");
                mismatches++;
            end
            else
            begin
                e = ray_q.pop_front();
                names = '{"origin_x", "origin_y", "origin_z",
                          "direction_x", "direction_y", "direction_z"};
                exp_f = '{e.org.x, e.org.y, e.org.z, e.dir.x, e.dir.y, e.dir.z};
                act_f = '{origin_x, origin_y, origin_z, direction_x, direction_y, direction_z};
                for (int i = 0; i < 6; i++)
                    if (exp_f[i] !== act_f[i])
                    begin
                        $error("%s: expected %0d, got %0d", names[i], exp_f[i], act_f[i]);
                        mismatches++;
                    end
                rays_checked++;
            end
        end
    end

    initial
    begin
        logic [RES_W-1:0] col, row;
        int               hres;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        out_ready = 1'b0;
        send_idle = 36;
        recv_idle = 47;
        mismatches = 0;
        pixels_sent = 0;
        rays_checked = 0;
        writes_done = 0;
        camera_regs = '{60'd0, 60'd4096, 60'd4294967296, 60'd640, 60'd480, 60'd4096, 60'd4096};

        add_pixel(320, 240, 1, -2048, -2048, 524287);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel('hAAA, 'h555);
        add_pixel('h555, 'hAAA);
        add_write(REG_VIEW, 60'd0);
        add_write(REG_UP, 60'd0);
        add_pixel(100, 7, 1, 0, 0, 0);
        add_write(REG_VIEW, pack_vec(0, 4096, 0));
        add_write(REG_UP, pack_vec(0, 4096, 0));
        add_pixel(3, 3);
        add_write(REG_UP, pack_vec(0, 0, -4096));
        add_write(REG_TANGENT, 60'd0);
        add_pixel(17, 400);
        add_write(REG_HRES, 60'hFFF_FFFF_FFFF_E000);
        add_write(REG_VRES, 60'hFFF_FFFF_FFFF_E000);
        add_pixel(4095, 0);
        add_write(REG_CAMERA, pack_vec(524287, 524287, 524287));
        add_write(REG_PITCH, 60'h7FFFF);
        add_pixel(4095, 4095);
        add_pixel(0, 4095);
        add_write(REG_UNUSED, '1);
        add_pixel(12, 34);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[k])
            if (stim_rows[k].kind == ROW_WRITE)
                write_register(stim_rows[k].idx, stim_rows[k].data);
            else
                send_pixel(stim_rows[k].col, stim_rows[k].row, stim_rows[k].typed,
                           stim_rows[k].org);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            send_idle = (p < 2) ? 36 : (p < 4) ? 47 : 0;
            recv_idle = (p < 2) ? 47 : (p < 4) ? 36 : 0;
            if (p == 3)
            begin
                write_register(REG_CAMERA, '1);
                write_register(REG_VIEW, pack_vec(-524288, 524287, -524288));
                write_register(REG_UP, pack_vec(524287, -524288, 524287));
                write_register(REG_HRES, 60'd4096);
                write_register(REG_VRES, 60'd4096);
                write_register(REG_PITCH, 60'h7FFFF);
                write_register(REG_TANGENT, 60'h7FFFF);
            end
            else
            begin
                write_register(REG_CAMERA, (p == 1) ? CFG_W'({$urandom, $urandom})
                               : pack_vec(rand_comp(), rand_comp(), rand_comp()));
                write_register(REG_VIEW, pack_vec(rand_comp(), rand_comp(), rand_comp()));
                write_register(REG_UP, pack_vec(rand_comp(), rand_comp(), rand_comp()));
                write_register(REG_HRES, (p == 5) ? 60'd1 : 60'($urandom_range(4096, 1)));
                write_register(REG_VRES, (p == 5) ? 60'd1 : 60'($urandom_range(4096, 1)));
                write_register(REG_PITCH, (p == 5) ? 60'd1 : 60'($urandom_range(8192, 1)));
                write_register(REG_TANGENT, (p == 5) ? 60'd1 : 60'($urandom_range(16384, 1)));
            end
            hres = int'(camera_regs[REG_HRES]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(9) < 8 && hres >= 1 && hres <= 4096)
                begin
                    col = RES_W'($urandom_range(hres - 1));
                    row = RES_W'($urandom_range(4095) % int'(camera_regs[REG_VRES]));
                end
                else
                begin
                    col = RES_W'($urandom);
                    row = RES_W'($urandom);
                end
                send_pixel(col, row, 0, '0);
            end
        end

        in_valid <= 1'b0;
        while (ray_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d pixels over %0d register writes and %0d idle settings.",
                 pixels_sent, writes_done, 3);
        $display("Checked %0d rays, %0d field mismatches.", rays_checked, mismatches);
        if (mismatches == 0 && ray_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
